>>> src/e2e_counter_checksum_framer_top_assert.svh
// assertion macros for the e2e counter checksum framer
`ifndef E2E_COUNTER_CHECKSUM_FRAMER_TOP_ASSERT_SVH
`define E2E_COUNTER_CHECKSUM_FRAMER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define E2E_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define E2E_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/e2eccf_pkg.sv
// shared types, constants and checksum helper for the framer
`timescale 1ns / 1ps

package e2eccf_pkg;

  localparam int unsigned DATA_DEPTH_DEF = 4;

  // key codes and counter limits
  localparam logic [7:0] SEND_CODE   = 8'd35;
  localparam logic [7:0] COUNTER_TOP = 8'd254;
  localparam logic [7:0] LIMIT_RESET = 8'd2;

  // configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic REG_ADVANCE_LIMIT = 1'b0;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic store_key;
    logic start_frame;
    logic load_byte;
    logic end_frame;
  } cmd_t;

  typedef struct packed {
    logic key_zero;
    logic key_send;
    logic fill_empty;
    logic fill_full;
    logic out_free;
    logic at_checksum;
  } status_t;

  // add both nibbles of a byte into a 4-bit end-around-carry sum
  function automatic logic [3:0] nibble_fold(input logic [3:0] acc, input logic [7:0] b);
    logic [5:0] s;
    logic [4:0] t;
    s = {2'b00, acc} + {2'b00, b[3:0]} + {2'b00, b[7:4]};
    t = {1'b0, s[3:0]} + {3'b000, s[5:4]};
    return t[3:0] + {3'b000, t[4]};
  endfunction

endpackage

>>> src/e2e_counter_checksum_framer_top.sv
// top level of the e2e alive counter and nibble checksum framer
//
//  channel  direction  handshake          payload
//  in_      request in in_valid/in_stall  in_key_code
//  out_     result out out_valid/out_stall out_frame_byte, out_byte_position,
//                                          out_frame_length, out_last
//  cfg      apb write  psel/penable/pready paddr, pwdata, prdata
//
// a data or empty key is taken while idle; a send key with n buffered bytes starts the
// frame, then loads its n + 2 frame bytes into the result register one at a time.
// the emit sequencer holds in_stall high until the checksum byte is loaded.
// out_stall holds the result register and the sequencer waits on it.
// reset is synchronous: counter, fill level and limit return to their reset values.
`timescale 1ns / 1ps

module e2e_counter_checksum_framer_top #(
  parameter int unsigned DATA_DEPTH = e2eccf_pkg::DATA_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_key_code,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_frame_byte,
  output logic [2:0]                       out_byte_position,
  output logic [2:0]                       out_frame_length,
  output logic                             out_last,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [e2eccf_pkg::PADDR_W-1:0]   paddr,
  input  logic [e2eccf_pkg::PDATA_W-1:0]   pwdata,
  output logic [e2eccf_pkg::PDATA_W-1:0]   prdata,
  output logic                             pready
);

  e2eccf_pkg::cmd_t    cmd;
  e2eccf_pkg::status_t st;
  logic                limit_wr;
  logic [7:0]          limit_q;
  logic                reg_hit;

  // register decode
  assign pready   = 1'b1;
  assign reg_hit  = (paddr[e2eccf_pkg::PADDR_W-1] == e2eccf_pkg::REG_ADVANCE_LIMIT);
  assign limit_wr = psel && penable && pwrite && reg_hit;
  assign prdata   = reg_hit ? e2eccf_pkg::PDATA_W'(limit_q) : '0;

  e2eccf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .st       (st),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  e2eccf_dp #(
    .DATA_DEPTH (DATA_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_key_code       (in_key_code),
    .cmd               (cmd),
    .limit_wr          (limit_wr),
    .limit_wdata       (pwdata[7:0]),
    .limit_q           (limit_q),
    .st                (st),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_frame_byte    (out_frame_byte),
    .out_byte_position (out_byte_position),
    .out_frame_length  (out_frame_length),
    .out_last          (out_last)
  );

  // checks
`include "e2e_counter_checksum_framer_top_assert.svh"

  `E2E_ASSERT_IMPL(a_last_position, out_valid && out_last, out_byte_position == 3'(out_frame_length - 3'd1), "checksum byte not at end of frame")
  `E2E_ASSERT_IMPL(a_last_high_nibble, out_valid && out_last, out_frame_byte[7:4] == 4'h0, "checksum byte high nibble set")
  `E2E_ASSERT_IMPL(a_load_when_free, cmd.load_byte, st.out_free, "result register overwritten")
  `E2E_ASSERT_NEXT(a_send_stalls, in_valid && !in_stall && st.key_send && !st.fill_empty, in_stall, "frame start did not stall input")

endmodule

>>> src/e2eccf_ctrl.sv
// controller state machine: key decode handling and frame emission sequencing
`timescale 1ns / 1ps

module e2eccf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  e2eccf_pkg::status_t st,
  output logic                in_stall,
  output e2eccf_pkg::cmd_t    cmd
);

  e2eccf_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= e2eccf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      e2eccf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && !st.key_zero) begin
          if (!st.key_send) begin
            cmd.store_key = !st.fill_full;
          end else if (!st.fill_empty) begin
            cmd.start_frame = 1'b1;
            state_nxt       = e2eccf_pkg::ST_EMIT;
          end
        end
      end
      e2eccf_pkg::ST_EMIT: begin
        if (st.out_free) begin
          cmd.load_byte = 1'b1;
          if (st.at_checksum) begin
            cmd.end_frame = 1'b1;
            state_nxt     = e2eccf_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = e2eccf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/e2eccf_dp.sv
// datapath: data buffer, alive counter, checksum accumulator and result register
`timescale 1ns / 1ps

module e2eccf_dp #(
  parameter int unsigned DATA_DEPTH = e2eccf_pkg::DATA_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_key_code,
  input  e2eccf_pkg::cmd_t    cmd,
  input  logic                limit_wr,
  input  logic [7:0]          limit_wdata,
  output logic [7:0]          limit_q,
  output e2eccf_pkg::status_t st,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [7:0]          out_frame_byte,
  output logic [2:0]          out_byte_position,
  output logic [2:0]          out_frame_length,
  output logic                out_last
);

  localparam int unsigned FILL_W = $clog2(DATA_DEPTH + 1);
  localparam int unsigned IDX_W  = $clog2(DATA_DEPTH + 2);
  localparam int unsigned ADDR_W = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;

  logic [7:0]        data_r [DATA_DEPTH];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [7:0]        alive_r, alive_nxt;
  logic [7:0]        adv_r, adv_nxt;
  logic [7:0]        limit_r;
  logic [3:0]        acc_r, acc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        byte_r;
  logic [2:0]        pos_r;
  logic [2:0]        len_r;
  logic              last_r;

  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  chk_idx;
  logic [7:0]        sel_byte;
  logic [3:0]        len_sum;

  // key decode and buffer status
  assign chk_idx = IDX_W'(fill_r) + IDX_W'(1);
  assign rd_idx  = idx_r - IDX_W'(1);
  assign len_sum = 4'(fill_r) + 4'd2;

  always_comb begin
    st.key_zero    = (in_key_code == 8'd0);
    st.key_send    = (in_key_code == e2eccf_pkg::SEND_CODE);
    st.fill_empty  = (fill_r == '0);
    st.fill_full   = (fill_r == FILL_W'(DATA_DEPTH));
    st.out_free    = !out_valid_r || !out_stall;
    st.at_checksum = (idx_r == chk_idx);
  end

  // frame byte selection: counter, data, then checksum
  always_comb begin
    if (idx_r == '0) begin
      sel_byte = alive_r;
    end else if (st.at_checksum) begin
      sel_byte = {4'h0, ~acc_r};
    end else begin
      sel_byte = data_r[rd_idx[ADDR_W-1:0]];
    end
  end

  // next values of control and counter state
  always_comb begin
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    alive_nxt     = alive_r;
    adv_nxt       = adv_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.store_key) begin
      fill_nxt = fill_r + FILL_W'(1);
    end
    if (cmd.start_frame) begin
      acc_nxt = 4'h0;
      idx_nxt = '0;
      if (adv_r < limit_r) begin
        alive_nxt = (alive_r == e2eccf_pkg::COUNTER_TOP) ? 8'd0 : alive_r + 8'd1;
        adv_nxt   = adv_r + 8'd1;
      end
    end
    if (cmd.load_byte) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = idx_r + IDX_W'(1);
      acc_nxt       = e2eccf_pkg::nibble_fold(acc_r, sel_byte);
    end
    if (cmd.end_frame) begin
      fill_nxt = '0;
      idx_nxt  = '0;
    end
  end

  // control and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      idx_r       <= '0;
      alive_r     <= 8'd0;
      adv_r       <= 8'd0;
      acc_r       <= 4'h0;
      out_valid_r <= 1'b0;
      limit_r     <= e2eccf_pkg::LIMIT_RESET;
    end else begin
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      alive_r     <= alive_nxt;
      adv_r       <= adv_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      if (limit_wr) begin
        limit_r <= limit_wdata;
      end
    end
  end

  // data buffer write
  always_ff @(posedge clk) begin
    if (cmd.store_key) begin
      data_r[fill_r[ADDR_W-1:0]] <= in_key_code;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      byte_r <= sel_byte;
      pos_r  <= 3'(idx_r);
      len_r  <= len_sum[2:0];
      last_r <= st.at_checksum;
    end
  end

  assign limit_q           = limit_r;
  assign out_valid         = out_valid_r;
  assign out_frame_byte    = byte_r;
  assign out_byte_position = pos_r;
  assign out_frame_length  = len_r;
  assign out_last          = last_r;

endmodule
